// File: design/event_timer_table_defines.svh
// Assertion macros for the event timer table.
// Used by the top level only; bodies are empty when SYNTHESIS is set.
`ifndef EVENT_TIMER_TABLE_DEFINES_SVH
`define EVENT_TIMER_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication on clk, held off during reset
`define ETT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("event_timer_table check failed");
// next-cycle implication on clk, held off during reset
`define ETT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("event_timer_table check failed");
`else
`define ETT_ASSERT_IMP(lbl, ante, cons)
`define ETT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: design/ett_pkg.sv
// Shared types and constants for the event timer table.
// No dependencies; imported by every module of the block.
package ett_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int TIME_BITS   = 40;
	localparam int ID_BITS     = 8;
	localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

	localparam logic [IDX_BITS-1:0] LAST_IDX   = IDX_BITS'(TABLE_DEPTH - 1);
	localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(TABLE_DEPTH);

	// operation codes
	localparam logic [1:0] OP_SCHEDULE = 2'd0;
	localparam logic [1:0] OP_REMOVE   = 2'd1;
	localparam logic [1:0] OP_QUERY    = 2'd2;
	localparam logic [1:0] OP_FIRE     = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// one table slot as it travels round the ring
	typedef struct packed {
		logic                 valid;
		logic [ID_BITS-1:0]   id;
		logic [TIME_BITS-1:0] ticks;
	} entry_t;

endpackage

// File: design/ett_cell.sv
// One slot of the circulating table: valid bit, id and time.
// Depends on ett_pkg for entry_t.
module ett_cell import ett_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift_en,
	input  entry_t d,
	output entry_t q
);

	logic                 valid_q;
	logic [ID_BITS-1:0]   id_q;
	logic [TIME_BITS-1:0] ticks_q;

	// valid bit is cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= d.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (shift_en) begin
			id_q    <= d.id;
			ticks_q <= d.ticks;
		end
	end

	assign q = '{valid: valid_q, id: id_q, ticks: ticks_q};

endmodule

// File: design/ett_ring.sv
// Ring of ett_cell slots; cell 0 presents the head, the last cell takes the
// entry written back by the head logic. Depends on ett_pkg and ett_cell.
module ett_ring import ett_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift_en,
	input  entry_t head_in,
	output entry_t head_out
);

	entry_t chain [TABLE_DEPTH];

	// each cell hands its entry one place towards the head per shift
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		entry_t cell_d;
		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign cell_d = head_in;
		end else begin : g_mid
			assign cell_d = chain[i+1];
		end
		ett_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.d        (cell_d),
			.q        (chain[i])
		);
	end

	assign head_out = chain[0];

endmodule

// File: design/event_timer_table.sv
// Event timer table. Each item takes one pass of the slot ring past the head
// comparator (S_SCAN) for schedule, remove, query and fire; a fire that finds
// an entry takes a second pass (S_APPLY) to subtract, then S_FIN loads the
// result register. One item is in work at a time: a new item is taken only in
// S_IDLE, and S_FIN waits while a held result has not yet been taken.
// Reset clears all valid bits and the count at once; there is no clearing pass.
`include "event_timer_table_defines.svh"

module event_timer_table import ett_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic [ID_BITS-1:0]   event_id,
	input  logic [TIME_BITS-1:0] due_ticks,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [ID_BITS-1:0]   next_id,
	output logic [TIME_BITS-1:0] next_ticks,
	output logic [CNT_BITS-1:0]  pending_count
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0]           state_q;
	logic [IDX_BITS-1:0]  cnt_q;
	logic [CNT_BITS-1:0]  count_q;
	logic                 found_q;
	logic [1:0]           op_q;
	logic [ID_BITS-1:0]   id_q;
	logic [TIME_BITS-1:0] ticks_q;
	logic [ID_BITS-1:0]   best_id_q;
	logic [TIME_BITS-1:0] best_ticks_q;
	logic [IDX_BITS-1:0]  best_idx_q;

	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [ID_BITS-1:0]   next_id_q;
	logic [TIME_BITS-1:0] next_ticks_q;
	logic [CNT_BITS-1:0]  pending_q;

	entry_t head_out;
	entry_t head_in;
	logic   shift_en;
	logic   hit;
	logic   accept;
	logic   last;
	logic   search_op;
	logic   out_free;

	logic [1:0]           status_nx;
	logic [CNT_BITS-1:0]  count_nx;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign shift_en  = (state_q == S_SCAN) || (state_q == S_APPLY);
	assign last      = (cnt_q == LAST_IDX);
	assign search_op = (op_q == OP_QUERY) || (op_q == OP_FIRE);
	assign out_free  = !out_valid_q || out_ready;

	ett_ring u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (shift_en),
		.head_in  (head_in),
		.head_out (head_out)
	);

	// head logic: look at the slot passing the head, write it back modified
	always_comb begin
		head_in = head_out;
		hit     = 1'b0;
		if (state_q == S_SCAN) begin
			case (op_q)
				OP_SCHEDULE: begin
					if (!found_q && !head_out.valid) begin
						head_in.valid = 1'b1;
						head_in.id    = id_q;
						head_in.ticks = ticks_q;
						hit           = 1'b1;
					end
				end
				OP_REMOVE: begin
					if (!found_q && head_out.valid && (head_out.id == id_q)) begin
						head_in.valid = 1'b0;
						hit           = 1'b1;
					end
				end
				default: begin
					// strict less-than keeps the lowest index on a tie
					if (head_out.valid && (!found_q || (head_out.ticks < best_ticks_q))) begin
						hit = 1'b1;
					end
				end
			endcase
		end else if (state_q == S_APPLY) begin
			if (head_out.valid) begin
				head_in.ticks = head_out.ticks - best_ticks_q;
				if (cnt_q == best_idx_q) begin
					head_in.valid = 1'b0;
				end
			end
		end
	end

	// result status and updated count
	always_comb begin
		status_nx = ST_OK;
		count_nx  = count_q;
		case (op_q)
			OP_SCHEDULE: begin
				if (found_q) begin
					count_nx = count_q + CNT_BITS'(1);
				end else begin
					status_nx = ST_FULL;
				end
			end
			OP_REMOVE: begin
				if (found_q) begin
					count_nx = count_q - CNT_BITS'(1);
				end else begin
					status_nx = ST_NOT_FOUND;
				end
			end
			OP_FIRE: begin
				if (found_q) begin
					count_nx = count_q - CNT_BITS'(1);
				end else begin
					status_nx = ST_EMPTY;
				end
			end
			default: begin
				if (!found_q) begin
					status_nx = ST_EMPTY;
				end
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: loaded on finish, emptied when taken
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					cnt_q <= last ? '0 : cnt_q + IDX_BITS'(1);
					if (last) begin
						state_q <= ((op_q == OP_FIRE) && (found_q || hit)) ? S_APPLY : S_FIN;
					end
				end
				S_APPLY: begin
					cnt_q <= last ? '0 : cnt_q + IDX_BITS'(1);
					if (last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						count_q <= count_nx;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item capture, running minimum and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			id_q    <= event_id;
			ticks_q <= due_ticks;
		end
		if ((state_q == S_SCAN) && hit && search_op) begin
			best_id_q    <= head_out.id;
			best_ticks_q <= head_out.ticks;
			best_idx_q   <= cnt_q;
		end
		if ((state_q == S_FIN) && out_free) begin
			status_q     <= status_nx;
			next_id_q    <= (search_op && found_q) ? best_id_q : '0;
			next_ticks_q <= (search_op && found_q) ? best_ticks_q : '0;
			pending_q    <= count_nx;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign next_id       = next_id_q;
	assign next_ticks    = next_ticks_q;
	assign pending_count = pending_q;

	// checks
	`ETT_ASSERT_IMP(a_count_range, 1'b1, count_q <= FULL_COUNT)
	`ETT_ASSERT_NEXT(a_accept_starts_scan, accept, (state_q == S_SCAN) && (cnt_q == '0))
	`ETT_ASSERT_IMP(a_full_means_full, out_valid && (status == ST_FULL), pending_count == FULL_COUNT)
	`ETT_ASSERT_IMP(a_empty_means_empty, out_valid && (status == ST_EMPTY), pending_count == '0)

endmodule
